>>> src/ihdu_pkg.sv
// ----------------------------------------------------------------------------
// ihdu_pkg
// Shared sizes, register indexes and reset values for the inverted-level
// half-duplex UART.
// ----------------------------------------------------------------------------
package ihdu_pkg;

  localparam int MAX_FRAME = 32;
  localparam int FRAME_AW  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int FRAME_CW  = $clog2(MAX_FRAME + 1);

  localparam logic [FRAME_CW-1:0] FRAME_FULL = FRAME_CW'(MAX_FRAME);

  localparam int BIT_TICKS_W = 16;
  localparam int TURN_TICKS_W = 20;
  localparam int TICK_W = 20;
  localparam int BIT_IDX_W = 4;
  localparam int RX_SHIFT_W = 9;

  localparam logic [BIT_IDX_W-1:0] RX_SAMPLES = 4'd9;
  localparam logic [BIT_IDX_W-1:0] TX_BITS    = 4'd11;
  localparam logic [BIT_IDX_W-1:0] DATA_BITS  = 4'd8;

  localparam logic [BIT_TICKS_W-1:0]  BIT_TICKS_RST  = 16'd2083;
  localparam logic [TURN_TICKS_W-1:0] TURN_TICKS_RST = 20'd24000;

  typedef enum logic {
    CFG_BIT_TICKS  = 1'b0,
    CFG_TURN_TICKS = 1'b1
  } cfg_idx_t;

endpackage

>>> src/ihdu_frame_ram.sv
// ----------------------------------------------------------------------------
// ihdu_frame_ram
// Frame byte store: one write port, one registered read port, with a
// same-cycle write forwarded to the read data.
// ----------------------------------------------------------------------------
module ihdu_frame_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ihdu_pkg::FRAME_AW-1:0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic [ihdu_pkg::FRAME_AW-1:0] rd_addr,
  output logic [7:0]                   rd_data
);

  logic [7:0] mem [ihdu_pkg::MAX_FRAME];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/inverted_half_duplex_uart.sv
// ----------------------------------------------------------------------------
// inverted_half_duplex_uart
// Single-wire UART, 8 data bits and 2 stop bits, idle low and start high.
// Receives while idle, sends a stored frame after a driven-low turnaround.
//
//   channel | direction | handshake             | payload
//   in      | in        | in_valid / in_ready   | line_in action send_byte send_last
//   out     | out       | out_valid / out_ready | line_out line_drive rx_valid rx_byte
//           |           |                       | rx_stop_error busy_res push_rejected tx_done
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One beat in per cycle unless the output stalls, one registered result per beat.
// The frame store read for the next byte is issued from the next send index
// as each input beat is taken, so the transmit level is ready on every tick.
// A stalled output register holds its beat and blocks input; cfg is always ready.
// Synchronous reset restores the register defaults and an idle, armed receiver.
// ----------------------------------------------------------------------------
module inverted_half_duplex_uart (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        line_in,
  input  logic        action,
  input  logic [7:0]  send_byte,
  input  logic        send_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        line_out,
  output logic        line_drive,
  output logic        rx_valid,
  output logic [7:0]  rx_byte,
  output logic        rx_stop_error,
  output logic        busy_res,
  output logic        push_rejected,
  output logic        tx_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RX,
    MODE_TURN,
    MODE_TX
  } mode_t;

  logic [ihdu_pkg::BIT_TICKS_W-1:0]  bit_ticks;
  logic [ihdu_pkg::TURN_TICKS_W-1:0] turnaround_ticks;

  mode_t                            mode, mode_next;
  logic                             prev_line;
  logic [ihdu_pkg::TICK_W-1:0]      tick_count, tick_count_next;
  logic [ihdu_pkg::BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic [ihdu_pkg::RX_SHIFT_W-1:0]  rx_shift, rx_shift_next;
  logic [ihdu_pkg::FRAME_CW-1:0]    frame_count, frame_count_next;
  logic [ihdu_pkg::FRAME_CW-1:0]    send_index, send_index_next;

  logic       step;
  logic       wr_en;
  logic [7:0] rd_data;
  logic [ihdu_pkg::FRAME_AW-1:0] rd_addr;

  logic       lvl, drive, rxv, rxe, rej, done;
  logic [7:0] rxb;

  logic [ihdu_pkg::BIT_TICKS_W-1:0] period;
  logic [ihdu_pkg::BIT_TICKS_W:0]   period_x15;
  logic [ihdu_pkg::BIT_IDX_W-1:0]   bit_m1;

  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign period     = (bit_ticks == '0) ? ihdu_pkg::BIT_TICKS_W'(1) : bit_ticks;
  assign period_x15 = {1'b0, period} + {2'b0, period[ihdu_pkg::BIT_TICKS_W-1:1]};
  assign bit_m1     = bit_index - ihdu_pkg::BIT_IDX_W'(1);

  always_comb begin
    mode_next        = mode;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    rx_shift_next    = rx_shift;
    frame_count_next = frame_count;
    send_index_next  = send_index;
    wr_en = 1'b0;
    lvl   = 1'b0;
    drive = 1'b0;
    rxv   = 1'b0;
    rxe   = 1'b0;
    rxb   = 8'd0;
    rej   = 1'b0;
    done  = 1'b0;

    if (action) begin
      if (mode == MODE_TURN || mode == MODE_TX) begin
        rej = 1'b1;
      end else if (frame_count >= ihdu_pkg::FRAME_FULL) begin
        rej = 1'b1;
        frame_count_next = '0;
      end else begin
        wr_en = 1'b1;
        frame_count_next = frame_count + ihdu_pkg::FRAME_CW'(1);
        if (send_last) begin
          if (mode != MODE_IDLE) begin
            rej = 1'b1;
            frame_count_next = '0;
          end else begin
            mode_next       = MODE_TURN;
            tick_count_next = (turnaround_ticks == '0) ? ihdu_pkg::TICK_W'(1)
                                                       : turnaround_ticks;
            bit_index_next  = '0;
            send_index_next = '0;
          end
        end
      end
    end

    case (mode_next)
      MODE_TURN, MODE_TX: begin
        drive = 1'b1;
        if (mode_next == MODE_TX) begin
          if (bit_index_next == '0) begin
            lvl = 1'b1;
          end else if (bit_index_next <= ihdu_pkg::DATA_BITS) begin
            lvl = ~rd_data[bit_m1[2:0]];
          end
        end
        if (tick_count_next != '0) begin
          tick_count_next = tick_count_next - ihdu_pkg::TICK_W'(1);
        end
        if (tick_count_next == '0) begin
          tick_count_next = {4'b0, period};
          if (mode_next == MODE_TURN) begin
            mode_next       = MODE_TX;
            bit_index_next  = '0;
            send_index_next = '0;
          end else begin
            bit_index_next = bit_index_next + ihdu_pkg::BIT_IDX_W'(1);
            if (bit_index_next >= ihdu_pkg::TX_BITS) begin
              bit_index_next  = '0;
              send_index_next = send_index_next + ihdu_pkg::FRAME_CW'(1);
              if (send_index_next >= frame_count_next) begin
                done             = 1'b1;
                mode_next        = MODE_IDLE;
                frame_count_next = '0;
                send_index_next  = '0;
                tick_count_next  = '0;
              end
            end
          end
        end
      end
      MODE_RX: begin
        if (tick_count_next != '0) begin
          tick_count_next = tick_count_next - ihdu_pkg::TICK_W'(1);
        end
        if (tick_count_next == '0) begin
          if (bit_index_next < ihdu_pkg::RX_SAMPLES) begin
            rx_shift_next[bit_index_next] = rx_shift_next[bit_index_next] | line_in;
          end
          bit_index_next  = bit_index_next + ihdu_pkg::BIT_IDX_W'(1);
          tick_count_next = {4'b0, period};
          if (bit_index_next >= ihdu_pkg::RX_SAMPLES) begin
            rxv = 1'b1;
            if (rx_shift_next[8]) begin
              rxe = 1'b1;
            end else begin
              rxb = ~rx_shift_next[7:0];
            end
            mode_next       = MODE_IDLE;
            bit_index_next  = '0;
            tick_count_next = '0;
          end
        end
      end
      default: begin
        if (!prev_line && line_in) begin
          mode_next       = MODE_RX;
          tick_count_next = {3'b0, period_x15};
          bit_index_next  = '0;
          rx_shift_next   = '0;
        end
      end
    endcase
  end

  assign rd_addr = step ? send_index_next[ihdu_pkg::FRAME_AW-1:0]
                        : send_index[ihdu_pkg::FRAME_AW-1:0];

  ihdu_frame_ram u_frame_ram (
    .clk     (clk),
    .wr_en   (step && wr_en),
    .wr_addr (frame_count[ihdu_pkg::FRAME_AW-1:0]),
    .wr_data (send_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks        <= ihdu_pkg::BIT_TICKS_RST;
      turnaround_ticks <= ihdu_pkg::TURN_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ihdu_pkg::CFG_BIT_TICKS:  bit_ticks <= cfg_data[ihdu_pkg::BIT_TICKS_W-1:0];
        ihdu_pkg::CFG_TURN_TICKS: turnaround_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      prev_line   <= 1'b0;
      tick_count  <= '0;
      bit_index   <= '0;
      rx_shift    <= '0;
      frame_count <= '0;
      send_index  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        mode        <= mode_next;
        prev_line   <= line_in;
        tick_count  <= tick_count_next;
        bit_index   <= bit_index_next;
        rx_shift    <= rx_shift_next;
        frame_count <= frame_count_next;
        send_index  <= send_index_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      line_out      <= lvl;
      line_drive    <= drive;
      rx_valid      <= rxv;
      rx_byte       <= rxb;
      rx_stop_error <= rxe;
      busy_res      <= (mode_next != MODE_IDLE);
      push_rejected <= rej;
      tx_done       <= done;
    end
  end

  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= ihdu_pkg::FRAME_FULL)
    else $error("frame count past capacity");

  a_send_in_frame: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_TX) |-> (send_index < frame_count))
    else $error("send index outside frame");

  a_rx_not_driving: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rx_valid) |-> !line_drive)
    else $error("reception completed while driving");

  a_done_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_done) |-> (line_drive && !line_out && !busy_res))
    else $error("done beat not driven low or still busy");

endmodule

>>> tb/ihdu_checker.sv
// ----------------------------------------------------------------------------
// ihdu_checker
// Watches the input, output and register channels of the inverted-level
// half-duplex UART. It runs a cycle-exact line model on every accepted input
// beat, queues the expected result beat, and compares each accepted result
// beat field by field. It reports the failure count, the number of results
// still owed, and whether the modeled line is idle.
// ----------------------------------------------------------------------------
module ihdu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        line_in,
  input  logic        action,
  input  logic [7:0]  send_byte,
  input  logic        send_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        line_out,
  input  logic        line_drive,
  input  logic        rx_valid,
  input  logic [7:0]  rx_byte,
  input  logic        rx_stop_error,
  input  logic        busy_res,
  input  logic        push_rejected,
  input  logic        tx_done,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  output int          errors,
  output int          pending,
  output logic        idle
);

  typedef enum logic [1:0] {
    UART_IDLE,
    UART_RX,
    UART_TURN,
    UART_TX
  } uart_mode_t;

  typedef struct packed {
    logic       line_out;
    logic       line_drive;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_stop_error;
    logic       busy_res;
    logic       push_rejected;
    logic       tx_done;
  } uart_tick_t;

  uart_tick_t expected_ticks[$];

  logic [ihdu_pkg::BIT_TICKS_W-1:0]  bit_cfg;
  logic [ihdu_pkg::TURN_TICKS_W-1:0] turn_cfg;
  uart_mode_t                        mode_q;
  logic                              prev_line;
  logic [ihdu_pkg::TICK_W-1:0]       tick_cnt;
  logic [ihdu_pkg::BIT_IDX_W-1:0]    bit_idx;
  logic [ihdu_pkg::RX_SHIFT_W-1:0]   rx_shift;
  logic [7:0]                        frame_mem [ihdu_pkg::MAX_FRAME];
  int                                frame_cnt;
  int                                send_idx;
  int                                err_cnt;

  function automatic uart_tick_t advance_uart(input logic line, input logic act,
                                              input logic [7:0] data, input logic last);
    uart_tick_t r;
    logic [7:0] b;
    int         per;
    r = '0;
    per = (bit_cfg == 0) ? 1 : int'(bit_cfg);

    if (act) begin
      if (mode_q == UART_TURN || mode_q == UART_TX) begin
        r.push_rejected = 1'b1;
      end else if (frame_cnt >= ihdu_pkg::MAX_FRAME) begin
        r.push_rejected = 1'b1;
        frame_cnt = 0;
      end else begin
        frame_mem[frame_cnt] = data;
        frame_cnt++;
        if (last) begin
          if (mode_q != UART_IDLE) begin
            r.push_rejected = 1'b1;
            frame_cnt = 0;
          end else begin
            mode_q = UART_TURN;
            tick_cnt = (turn_cfg == 0) ? ihdu_pkg::TICK_W'(1) : turn_cfg;
            bit_idx = '0;
            send_idx = 0;
          end
        end
      end
    end

    if (mode_q == UART_TURN || mode_q == UART_TX) begin
      r.line_drive = 1'b1;
      if (mode_q == UART_TX) begin
        b = (send_idx < ihdu_pkg::MAX_FRAME) ? frame_mem[send_idx] : 8'h00;
        if (bit_idx == 0) r.line_out = 1'b1;
        else if (bit_idx <= ihdu_pkg::DATA_BITS) r.line_out = ~b[bit_idx - 1];
        else r.line_out = 1'b0;
      end
      if (tick_cnt > 0) tick_cnt--;
      if (tick_cnt == 0) begin
        if (mode_q == UART_TURN) begin
          mode_q = UART_TX;
          bit_idx = '0;
          send_idx = 0;
          tick_cnt = ihdu_pkg::TICK_W'(per);
        end else begin
          bit_idx++;
          tick_cnt = ihdu_pkg::TICK_W'(per);
          if (bit_idx >= ihdu_pkg::TX_BITS) begin
            bit_idx = '0;
            send_idx++;
            if (send_idx >= frame_cnt) begin
              r.tx_done = 1'b1;
              mode_q = UART_IDLE;
              frame_cnt = 0;
              send_idx = 0;
              tick_cnt = '0;
            end
          end
        end
      end
    end else if (mode_q == UART_RX) begin
      if (tick_cnt > 0) tick_cnt--;
      if (tick_cnt == 0) begin
        if (bit_idx < ihdu_pkg::RX_SAMPLES)
          rx_shift = rx_shift | (ihdu_pkg::RX_SHIFT_W'(line) << bit_idx);
        bit_idx++;
        tick_cnt = ihdu_pkg::TICK_W'(per);
        if (bit_idx >= ihdu_pkg::RX_SAMPLES) begin
          r.rx_valid = 1'b1;
          if (rx_shift[8]) r.rx_stop_error = 1'b1;
          else r.rx_byte = ~rx_shift[7:0];
          mode_q = UART_IDLE;
          bit_idx = '0;
          tick_cnt = '0;
        end
      end
    end else if (!prev_line && line) begin
      mode_q = UART_RX;
      tick_cnt = ihdu_pkg::TICK_W'((3 * per) / 2);
      bit_idx = '0;
      rx_shift = '0;
    end

    prev_line = line;
    r.busy_res = (mode_q != UART_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  initial err_cnt = 0;

  always @(posedge clk) begin
    uart_tick_t want;
    uart_tick_t got;
    if (rst) begin
      bit_cfg = ihdu_pkg::BIT_TICKS_RST;
      turn_cfg = ihdu_pkg::TURN_TICKS_RST;
      mode_q = UART_IDLE;
      prev_line = 1'b0;
      tick_cnt = '0;
      bit_idx = '0;
      rx_shift = '0;
      frame_cnt = 0;
      send_idx = 0;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      expected_ticks.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {line_out, line_drive, rx_valid, rx_byte, rx_stop_error, busy_res,
               push_rejected, tx_done};
        if (expected_ticks.size() == 0) begin
          $display("%0t: result beat with none expected, actual %0h", $time, got);
          err_cnt++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("line_out", 8'(want.line_out), 8'(got.line_out));
          check_field("line_drive", 8'(want.line_drive), 8'(got.line_drive));
          check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("rx_stop_error", 8'(want.rx_stop_error), 8'(got.rx_stop_error));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("push_rejected", 8'(want.push_rejected), 8'(got.push_rejected));
          check_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ihdu_pkg::CFG_BIT_TICKS) bit_cfg = cfg_data[ihdu_pkg::BIT_TICKS_W-1:0];
        else turn_cfg = cfg_data;
      end
      if (in_valid && in_ready)
        expected_ticks.push_back(advance_uart(line_in, action, send_byte, send_last));
    end
    errors <= err_cnt;
    pending <= expected_ticks.size();
    idle <= (mode_q == UART_IDLE);
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the inverted-level half-duplex UART. Directed ticks
// cover reset, zero and maximum periods, turnaround refusal, send requests
// during reception and on a start edge, stop errors, frame overflow and a full
// frame. Random phases then mix received bytes, some with bad stop bits or line
// glitches, sent frames and line noise under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        line_in = 1'b0;
  logic        action = 1'b0;
  logic [7:0]  send_byte = 8'h00;
  logic        send_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        line_out;
  logic        line_drive;
  logic        rx_valid;
  logic [7:0]  rx_byte;
  logic        rx_stop_error;
  logic        busy_res;
  logic        push_rejected;
  logic        tx_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  ihdu_pkg::cfg_idx_t cfg_index = ihdu_pkg::CFG_BIT_TICKS;
  logic [19:0] cfg_data = 20'h00000;
  int          errors;
  int          pending;
  logic        idle;

  int               cycle_cnt = 0;
  int               in_beats = 0;
  int               rand_start = 1000000000;
  int               settings = 0;
  bit               gaps_on = 1'b0;
  logic [15:0]      cur_bit = ihdu_pkg::BIT_TICKS_RST;

  inverted_half_duplex_uart DUT (.*);
  ihdu_checker CHK (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_cnt, pending);
      $display("FAIL inverted_half_duplex_uart");
      $finish;
    end
  end

  // Result side: random stalls, plus two long hold-offs during the random part.
  initial begin : result_side
    int holds_done;
    holds_done = 0;
    forever begin
      if (holds_done < 2 && in_beats >= rand_start + 100 + 150 * holds_done) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
        holds_done++;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic drive_tick(input logic line, input logic act, input logic [7:0] data,
                            input logic last);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_in <= line;
    action <= act;
    send_byte <= data;
    send_last <= last;
    do @(posedge clk); while (!in_ready);
    in_beats++;
  endtask

  // Hold the line low until the modeled UART is idle.
  task automatic settle_line();
    do drive_tick(1'b0, 1'b0, 8'($urandom), 1'($urandom)); while (!idle);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !idle);
  endtask

  task automatic write_periods(input bit set_bit, input logic [19:0] bit_word,
                               input bit set_turn, input logic [19:0] turn_word);
    if (set_bit) begin
      cfg_valid <= 1'b1;
      cfg_index <= ihdu_pkg::CFG_BIT_TICKS;
      cfg_data <= bit_word;
      do @(posedge clk); while (!cfg_ready);
      cur_bit = bit_word[15:0];
    end
    if (set_turn) begin
      cfg_valid <= 1'b1;
      cfg_index <= ihdu_pkg::CFG_TURN_TICKS;
      cfg_data <= turn_word;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic recv_byte_wave(input logic [7:0] data, input logic bad_stop);
    int   per;
    logic lvl;
    per = (cur_bit == 0) ? 1 : int'(cur_bit);
    settle_line();
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 0) lvl = 1'b1;
      else if (seg <= 8) lvl = ~data[seg-1];
      else lvl = bad_stop;
      for (int k = 0; k < per; k++)
        drive_tick(lvl ^ ($urandom_range(0, 59) == 0), $urandom_range(0, 29) == 0,
                   8'($urandom), 1'($urandom));
    end
    settle_line();
  endtask

  task automatic send_frame(input int n, input bit start_on_last);
    logic last;
    settle_line();
    for (int i = 0; i < n; i++) begin
      repeat ($urandom_range(0, 2)) drive_tick(1'b0, 1'b0, 8'($urandom), 1'($urandom));
      last = (i == n - 1);
      drive_tick(last && start_on_last, 1'b1, 8'($urandom), last);
    end
    do drive_tick($urandom_range(0, 3) == 0, $urandom_range(0, 19) == 0, 8'($urandom),
                  1'($urandom));
    while (!idle);
  endtask

  task automatic line_noise();
    settle_line();
    repeat ($urandom_range(10, 30))
      drive_tick($urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0, 8'($urandom),
                 $urandom_range(0, 2) == 0);
    settle_line();
  endtask

  initial begin : stimulus
    int          pick;
    logic [15:0] bit_val;
    bit          set_b;
    bit          set_t;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset periods: store bytes without requesting a send
    drive_tick(1'b0, 1'b1, 8'h00, 1'b0);
    drive_tick(1'b0, 1'b1, 8'hFF, 1'b0);
    drive_tick(1'b0, 1'b0, 8'hA5, 1'b1);

    // zero periods act as one tick
    drain();
    write_periods(1'b1, 20'hF0000, 1'b1, 20'h00000);
    drive_tick(1'b0, 1'b1, 8'h5A, 1'b1);
    drive_tick(1'b0, 1'b1, 8'h3C, 1'b0);
    do drive_tick(1'b0, 1'b0, 8'h00, 1'b0); while (!idle);
    recv_byte_wave(8'h00, 1'b0);
    recv_byte_wave(8'hFF, 1'b1);
    recv_byte_wave(8'h96, 1'b0);
    settle_line();
    drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
    drive_tick(1'b1, 1'b1, 8'h11, 1'b1);
    settle_line();
    send_frame(1, 1'b1);
    send_frame(ihdu_pkg::MAX_FRAME + 1, 1'b0);
    send_frame(ihdu_pkg::MAX_FRAME, 1'b0);

    // maximum periods: idle ticks and stored bytes only
    drain();
    write_periods(1'b1, 20'hFFFFF, 1'b1, 20'hFFFFF);
    repeat (6) drive_tick(1'b0, 1'b1, 8'($urandom), 1'b0);
    drive_tick(1'b0, 1'b0, 8'h00, 1'b0);

    rand_start = in_beats;
    gaps_on = 1'b1;
    while (in_beats < rand_start + RAND_ITEMS) begin
      if (in_beats >= rand_start + RAND_ITEMS - 250) gaps_on = 1'b0;
      drain();
      pick = $urandom_range(0, 7);
      bit_val = (pick == 0) ? 16'd4 : (pick == 1) ? 16'($urandom_range(12, 20))
                                                  : 16'($urandom_range(4, 8));
      set_b = $urandom_range(0, 3) != 0;
      set_t = $urandom_range(0, 3) != 0;
      // leave the maximum periods behind on the first pass
      if ((!set_b && !set_t) || in_beats == rand_start) begin
        set_b = 1'b1;
        set_t = 1'b1;
      end
      write_periods(set_b, {4'($urandom), bit_val}, set_t,
                    ($urandom_range(0, 3) == 0) ? 20'd1 : 20'($urandom_range(2, 40)));
      repeat ($urandom_range(2, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 9)
          recv_byte_wave(8'($urandom), $urandom_range(0, 5) == 0);
        else if (pick < 16)
          send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(5, 8)
                                                 : $urandom_range(1, 4),
                     $urandom_range(0, 7) == 0);
        else
          line_noise();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d input ticks over %0d register settings, zero and maximum included,",
             in_beats, settings);
    $display("with received bytes, sent frames, refusals, overflow and line noise.");
    if (errors == 0 && pending == 0) begin
      $display("PASS inverted_half_duplex_uart");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending);
      $display("FAIL inverted_half_duplex_uart");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ihdu_pkg.sv
src/ihdu_frame_ram.sv
src/inverted_half_duplex_uart.sv
tb/ihdu_checker.sv
tb/tb.sv
